/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the role negotiator.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PRN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property that must hold in the cycle after the trigger, outside reset.
`define PRN_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);

`endif

/* hw/rtl/prn_pkg.sv */
// Package of the role negotiator: beat types, packet descriptor, codes and sizes.
// Used by every RTL module of the block; depends on nothing.
`default_nettype none

package prn_pkg;

  localparam int SILENCE_WIDTH = 16;
  localparam int TIMEOUT_WIDTH = 16;
  localparam int CONN_CMP_W    = (SILENCE_WIDTH > TIMEOUT_WIDTH) ? SILENCE_WIDTH
                                                                  : TIMEOUT_WIDTH;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 2;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] ROLE_FLAG = 8'h01;

  typedef enum logic [1:0] {
    OP_RX_BYTE = 2'd0,
    OP_TICK    = 2'd1,
    OP_UPDATE  = 2'd2
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_START_BYTE = 2'd0,
    CFG_BATT_THR   = 2'd1,
    CFG_TIMEOUT    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_START2 = 3'd1,
    PH_FLAGS  = 3'd2,
    PH_SCORE  = 3'd3,
    PH_BALL   = 3'd4,
    PH_BATT   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    BEAT_START0 = 3'd0,
    BEAT_START1 = 3'd1,
    BEAT_FLAGS  = 3'd2,
    BEAT_SCORE  = 3'd3,
    BEAT_BALL   = 3'd4,
    BEAT_BATT   = 3'd5
  } beat_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
    logic [7:0] own_score;
    logic [7:0] own_ball_strength;
    logic       own_enabled;
    logic [7:0] own_battery;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       own_role;
    logic       link_connected;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic       own_enabled;
    logic       own_role;
    logic [7:0] own_score;
    logic [7:0] own_ball_strength;
    logic [7:0] own_battery;
    logic       link_connected;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/prn_fifo.sv */
// Short descriptor queue between the front and the back of the role negotiator.
// Depends on prn_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module prn_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire prn_pkg::desc_t   wdata,
  input  wire logic             pop,
  output prn_pkg::desc_t        rdata,
  output prn_pkg::q_stat_t      stat
);

  prn_pkg::desc_t                mem_r [prn_pkg::Q_DEPTH];
  logic [prn_pkg::Q_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [prn_pkg::Q_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [prn_pkg::Q_CW-1:0]      count_r, count_nxt;
  logic                          do_push, do_pop;

  assign stat.full  = (count_r == prn_pkg::Q_CW'(prn_pkg::Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == prn_pkg::Q_AW'(prn_pkg::Q_DEPTH - 1)) ? '0
                                                                       : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == prn_pkg::Q_AW'(prn_pkg::Q_DEPTH - 1)) ? '0
                                                                       : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `PRN_ASSERT(a_q_count_bound, count_r <= prn_pkg::Q_CW'(prn_pkg::Q_DEPTH), "queue count overflow")
  `PRN_ASSERT_NEXT(a_q_full_holds, stat.full && !pop, stat.full, "queue lost an entry")

endmodule

`default_nettype wire

/* hw/rtl/prn_front.sv */
// Front of the role negotiator: configuration, deframer, silence counter and role rule.
// Pushes one packet descriptor per update; depends on prn_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module prn_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  input  wire prn_pkg::in_beat_t               in_data,
  input  wire logic                            cfg_we,
  input  wire logic [prn_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [prn_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire prn_pkg::q_stat_t                q_stat,
  output logic                                 q_push,
  output prn_pkg::desc_t                       q_wdata
);

  logic [7:0]                          start_byte_r, start_byte_nxt;
  logic [7:0]                          batt_thr_r, batt_thr_nxt;
  logic [prn_pkg::TIMEOUT_WIDTH-1:0]   timeout_r, timeout_nxt;

  prn_pkg::phase_t                     phase_r, phase_nxt;
  logic [1:0]                          hold_flags_r, hold_flags_nxt;
  logic [7:0]                          hold_score_r, hold_score_nxt;
  logic [7:0]                          hold_ball_r, hold_ball_nxt;
  logic                                peer_role_r, peer_role_nxt;
  logic                                peer_en_r, peer_en_nxt;
  logic [7:0]                          peer_score_r, peer_score_nxt;
  logic [7:0]                          peer_ball_r, peer_ball_nxt;
  logic [7:0]                          peer_batt_r, peer_batt_nxt;
  logic                                my_role_r, my_role_nxt;
  logic                                pend_r, pend_nxt;
  logic [prn_pkg::SILENCE_WIDTH-1:0]   silence_r, silence_nxt;

  logic accept;
  logic conn;
  logic role_res;
  logic pend_res;
  logic byte_is_start;

  assign accept        = in_push && !q_stat.full;
  assign conn          = prn_pkg::CONN_CMP_W'(silence_r) < prn_pkg::CONN_CMP_W'(timeout_r);
  assign byte_is_start = (in_data.rx_byte == start_byte_r);

  // Role rule, first matching condition wins.
  always_comb begin
    role_res = my_role_r;
    pend_res = pend_r;
    if ((in_data.own_ball_strength == 8'd0) && (peer_ball_r == 8'd0)) begin
      pend_res = 1'b0;
    end else if (!in_data.own_enabled) begin
      role_res = 1'b1;
    end else if (!conn || !peer_en_r) begin
      role_res = 1'b0;
    end else if (pend_r) begin
      role_res = !my_role_r;
      pend_res = 1'b0;
    end else if ((in_data.own_battery < batt_thr_r) && (peer_batt_r < batt_thr_r) &&
                 (in_data.own_battery != peer_batt_r)) begin
      role_res = (in_data.own_battery > peer_batt_r);
    end else begin
      role_res = (in_data.own_score >= peer_score_r);
    end
  end

  always_comb begin
    start_byte_nxt = start_byte_r;
    batt_thr_nxt   = batt_thr_r;
    timeout_nxt    = timeout_r;
    if (cfg_we) begin
      unique case (cfg_index)
        prn_pkg::CFG_START_BYTE: start_byte_nxt = cfg_wdata[7:0];
        prn_pkg::CFG_BATT_THR:   batt_thr_nxt   = cfg_wdata[7:0];
        prn_pkg::CFG_TIMEOUT:    timeout_nxt    = cfg_wdata[prn_pkg::TIMEOUT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    hold_flags_nxt = hold_flags_r;
    hold_score_nxt = hold_score_r;
    hold_ball_nxt  = hold_ball_r;
    peer_role_nxt  = peer_role_r;
    peer_en_nxt    = peer_en_r;
    peer_score_nxt = peer_score_r;
    peer_ball_nxt  = peer_ball_r;
    peer_batt_nxt  = peer_batt_r;
    my_role_nxt    = my_role_r;
    pend_nxt       = pend_r;
    silence_nxt    = silence_r;
    q_push         = 1'b0;

    if (accept) begin
      unique case (in_data.opcode)
        prn_pkg::OP_RX_BYTE: begin
          unique case (phase_r)
            prn_pkg::PH_HUNT: begin
              if (byte_is_start) begin
                phase_nxt = prn_pkg::PH_START2;
              end
            end
            prn_pkg::PH_START2: begin
              phase_nxt = byte_is_start ? prn_pkg::PH_FLAGS : prn_pkg::PH_HUNT;
            end
            prn_pkg::PH_FLAGS: begin
              hold_flags_nxt = in_data.rx_byte[1:0];
              phase_nxt      = prn_pkg::PH_SCORE;
            end
            prn_pkg::PH_SCORE: begin
              hold_score_nxt = in_data.rx_byte;
              phase_nxt      = prn_pkg::PH_BALL;
            end
            prn_pkg::PH_BALL: begin
              hold_ball_nxt = in_data.rx_byte;
              phase_nxt     = prn_pkg::PH_BATT;
            end
            prn_pkg::PH_BATT: begin
              peer_role_nxt  = hold_flags_r[0];
              peer_en_nxt    = hold_flags_r[1];
              pend_nxt       = (peer_role_r != hold_flags_r[0]) &&
                               (my_role_r == hold_flags_r[0]);
              peer_score_nxt = hold_score_r;
              peer_ball_nxt  = hold_ball_r;
              peer_batt_nxt  = in_data.rx_byte;
              silence_nxt    = '0;
              phase_nxt      = prn_pkg::PH_HUNT;
            end
            default: phase_nxt = prn_pkg::PH_HUNT;
          endcase
        end
        prn_pkg::OP_TICK: begin
          if (silence_r != '1) begin
            silence_nxt = silence_r + 1'b1;
          end
        end
        prn_pkg::OP_UPDATE: begin
          my_role_nxt = role_res;
          pend_nxt    = pend_res;
          q_push      = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign q_wdata.start_byte        = start_byte_r;
  assign q_wdata.own_enabled       = in_data.own_enabled;
  assign q_wdata.own_role          = role_res & prn_pkg::ROLE_FLAG[0];
  assign q_wdata.own_score         = in_data.own_score;
  assign q_wdata.own_ball_strength = in_data.own_ball_strength;
  assign q_wdata.own_battery       = in_data.own_battery;
  assign q_wdata.link_connected    = conn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= 8'hFF;
      batt_thr_r   <= 8'd0;
      timeout_r    <= prn_pkg::TIMEOUT_WIDTH'(1000);
      phase_r      <= prn_pkg::PH_HUNT;
      peer_role_r  <= 1'b0;
      peer_en_r    <= 1'b0;
      peer_score_r <= 8'd0;
      peer_ball_r  <= 8'd0;
      peer_batt_r  <= 8'd0;
      my_role_r    <= 1'b0;
      pend_r       <= 1'b0;
      silence_r    <= '0;
    end else begin
      start_byte_r <= start_byte_nxt;
      batt_thr_r   <= batt_thr_nxt;
      timeout_r    <= timeout_nxt;
      phase_r      <= phase_nxt;
      peer_role_r  <= peer_role_nxt;
      peer_en_r    <= peer_en_nxt;
      peer_score_r <= peer_score_nxt;
      peer_ball_r  <= peer_ball_nxt;
      peer_batt_r  <= peer_batt_nxt;
      my_role_r    <= my_role_nxt;
      pend_r       <= pend_nxt;
      silence_r    <= silence_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_flags_r <= hold_flags_nxt;
    hold_score_r <= hold_score_nxt;
    hold_ball_r  <= hold_ball_nxt;
  end

  `PRN_ASSERT(a_phase_range, phase_r <= prn_pkg::PH_BATT, "deframer phase out of range")
  `PRN_ASSERT_NEXT(a_silence_sat, (silence_r == '1) && !(accept && (in_data.opcode == prn_pkg::OP_RX_BYTE)), silence_r == '1, "silence counter wrapped")

endmodule

`default_nettype wire

/* hw/rtl/prn_back.sv */
// Back of the role negotiator: turns each packet descriptor into six output beats.
// Depends on prn_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module prn_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire prn_pkg::desc_t    q_rdata,
  input  wire prn_pkg::q_stat_t  q_stat,
  output logic                   q_pop,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output prn_pkg::out_beat_t     out_data
);

  prn_pkg::desc_t   cur_r, cur_nxt;
  prn_pkg::beat_t   beat_r, beat_nxt;
  logic             busy_r, busy_nxt;
  logic             taken;
  logic             last;

  assign out_empty = !busy_r;
  assign last      = (beat_r == prn_pkg::BEAT_BATT);
  assign taken     = out_pop && busy_r;

  always_comb begin
    cur_nxt  = cur_r;
    beat_nxt = beat_r;
    busy_nxt = busy_r;
    q_pop    = 1'b0;
    if ((!busy_r || (taken && last)) && !q_stat.empty) begin
      q_pop    = 1'b1;
      cur_nxt  = q_rdata;
      beat_nxt = prn_pkg::BEAT_START0;
      busy_nxt = 1'b1;
    end else if (taken && last) begin
      busy_nxt = 1'b0;
    end else if (taken) begin
      beat_nxt = prn_pkg::beat_t'(beat_r + 3'd1);
    end
  end

  always_comb begin
    case (beat_r)
      prn_pkg::BEAT_START0, prn_pkg::BEAT_START1: out_data.tx_byte = cur_r.start_byte;
      prn_pkg::BEAT_FLAGS:  out_data.tx_byte = {6'd0, cur_r.own_enabled, cur_r.own_role};
      prn_pkg::BEAT_SCORE:  out_data.tx_byte = cur_r.own_score;
      prn_pkg::BEAT_BALL:   out_data.tx_byte = cur_r.own_ball_strength;
      default:              out_data.tx_byte = cur_r.own_battery;
    endcase
  end

  assign out_data.tx_last        = last;
  assign out_data.own_role       = cur_r.own_role;
  assign out_data.link_connected = cur_r.link_connected;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= prn_pkg::BEAT_START0;
      busy_r <= 1'b0;
    end else begin
      beat_r <= beat_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  `PRN_ASSERT(a_beat_range, !busy_r || (beat_r <= prn_pkg::BEAT_BATT), "beat counter out of range")
  `PRN_ASSERT_NEXT(a_packet_whole, taken && !last, busy_r, "packet cut short")

endmodule

`default_nettype wire

/* hw/rtl/peer_role_negotiator.sv */
// Top level of the two-node role negotiator: front, descriptor queue and back.
// Depends on prn_pkg, prn_front, prn_fifo and prn_back.
//
//   Channel  Ports                           Beat
//   input    in_push, in_full, in_data       one received byte, tick or update
//   result   out_empty, out_pop, out_data    one byte of an outgoing packet
//   config   cfg_we, cfg_index, cfg_wdata    one register write, no wait
//
// A byte or tick beat is taken while in_full is low and gives no result.
// An update beat is taken while in_full is low and yields six result beats, one per cycle while out_pop is high.
// The back drains one packet at a time and takes the next from the queue as the last beat of the one before is popped.
// Two packets wait in the descriptor queue; in_full rises while it is full.
// Reset is synchronous and leaves the block ready for a beat as soon as it is released.
`default_nettype none

module peer_role_negotiator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire prn_pkg::in_beat_t               in_data,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output prn_pkg::out_beat_t                   out_data,
  input  wire logic                            cfg_we,
  input  wire logic [prn_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [prn_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  prn_pkg::desc_t    q_wdata;
  prn_pkg::desc_t    q_rdata;
  prn_pkg::q_stat_t  q_stat;
  logic              q_push;
  logic              q_pop;

  assign in_full = q_stat.full;

  prn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  prn_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  prn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rdata   (q_rdata),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
